// File: src/htsd_pkg.sv
// Shared types and constants for the serialized-tree Huffman stream decoder.
// No dependencies; every other file refers to it by scoped names.
package htsd_pkg;

	localparam int BYTE_W                 = 8;
	localparam int BIT_CNT_W              = $clog2(BYTE_W + 1);
	localparam int NODE_W                 = 9;
	localparam int REPEAT_W               = 24;
	localparam int DEF_MAX_INTERNAL_NODES = 256;
	localparam int DEF_LENGTH_BITS        = 24;

	// decoder sequencer states
	typedef enum logic [2:0] {
		ST_BUILD,
		ST_ATTACH,
		ST_LOAD,
		ST_WALK,
		ST_DONE
	} state_t;

	// sequencer -> bit feeder
	typedef struct packed {
		logic take;   // consume the current bit
		logic flush;  // drop all bits left in the shift register
		logic hold;   // do not load a new byte this cycle
	} feed_ctl_t;

	// bit feeder -> sequencer
	typedef struct packed {
		logic avail;    // a bit is waiting
		logic cur_bit;  // that bit
		logic load;     // a buffered byte moves into the shift register now
		logic start;    // the byte being loaded opens a new chunk
	} feed_stat_t;

endpackage

// File: src/htsd_if.sv
// Valid/ready channel interfaces for compressed input bytes and decoded results.
// Depends on htsd_pkg for field widths.
interface htsd_in_if;
	logic                          valid;
	logic                          ready;
	logic [htsd_pkg::BYTE_W-1:0]   data_byte;
	logic                          chunk_start;

	modport source (output valid, data_byte, chunk_start, input ready);
	modport sink   (input valid, data_byte, chunk_start, output ready);
endinterface

interface htsd_out_if;
	logic                          valid;
	logic                          ready;
	logic [htsd_pkg::BYTE_W-1:0]   symbol;
	logic [htsd_pkg::REPEAT_W-1:0] repeat_count;
	logic                          last;
	logic                          tree_error;

	modport source (output valid, symbol, repeat_count, last, tree_error, input ready);
	modport sink   (input valid, symbol, repeat_count, last, tree_error, output ready);
endinterface

// File: src/huffman_tree_stream_decoder_top.sv
// Top level of the serialized-tree Huffman stream decoder: tree build, walk, result register.
// Depends on htsd_pkg, htsd_if (htsd_in_if, htsd_out_if) and htsd_bit_feeder.
//
//  channel   role   beat payload                                  handshake
//  -------   ----   ------------------------------------------    ---------------------
//  stream    sink   data_byte[7:0], chunk_start                   valid/ready
//  result    src    symbol[7:0], repeat_count[23:0], last,        valid/ready
//                   tree_error
//  cfg       sink   cfg_data[LENGTH_BITS-1:0] -> out_length       cfg_we, no wait
//
// Each input byte is taken into a one-beat buffer and shifted out one bit per cycle while the
// sequencer takes bits in BUILD or WALK. A completed leaf passes through ATTACH to hang it
// under its parent or to finish the root, through ATTACH again for each tree level it closes,
// and through LOAD first for each level whose parent entry is reloaded from the stack RAM.
// Reset clears the control state only; the child and stack RAMs need no clearing pass.
// A bit that produces a result waits while the result register is still full; the input
// buffer keeps taking one beat meanwhile.
module huffman_tree_stream_decoder_top #(
	parameter int MAX_INTERNAL_NODES = htsd_pkg::DEF_MAX_INTERNAL_NODES,
	parameter int LENGTH_BITS        = htsd_pkg::DEF_LENGTH_BITS
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [LENGTH_BITS-1:0] cfg_data,
	htsd_in_if.sink                stream,
	htsd_out_if.source             result
);

	localparam int SLOT_W  = $clog2(MAX_INTERNAL_NODES);
	localparam int DEPTH_W = $clog2(MAX_INTERNAL_NODES + 1);
	localparam int ENT_W   = SLOT_W + 1;   // stack entry: {left_filled, slot}
	localparam int NODE_W  = htsd_pkg::NODE_W;
	localparam int BYTE_W  = htsd_pkg::BYTE_W;
	localparam int REP_W   = htsd_pkg::REPEAT_W;

	// ------------------------------------------------------------------
	// Bit feeder
	// ------------------------------------------------------------------
	htsd_pkg::feed_ctl_t  fd_ctl;
	htsd_pkg::feed_stat_t fd_st;

	htsd_bit_feeder u_feed (
		.clk    (clk),
		.arst_n (arst_n),
		.stream (stream),
		.ctl    (fd_ctl),
		.st     (fd_st)
	);

	// ------------------------------------------------------------------
	// State
	// ------------------------------------------------------------------
	htsd_pkg::state_t state_q, state_d, state_n;

	logic [LENGTH_BITS-1:0]         out_len_q;
	logic [DEPTH_W-1:0]             depth_q;      // build stack depth
	logic [DEPTH_W-1:0]             node_cnt_q;   // internal nodes allocated
	logic [htsd_pkg::BIT_CNT_W-1:0] leaf_cnt_q;   // leaf bits still to collect
	logic [BYTE_W-1:0]              leaf_val_q;
	logic [LENGTH_BITS-1:0]         bytes_q;      // bytes emitted by the walk
	logic [ENT_W-1:0]               tos_q;        // top of the build stack
	logic [NODE_W-1:0]              v_q;          // subtree being attached
	logic [NODE_W-1:0]              root_q;
	logic [NODE_W-1:0]              walk_q;
	logic [NODE_W-1:0]              walk_d;

	// result register
	logic              out_valid_q;
	logic [BYTE_W-1:0] sym_q;
	logic [REP_W-1:0]  rep_q;
	logic              last_q;
	logic              err_q;

	// RAMs: child links per internal node, and the stack below its top entry
	logic [NODE_W-1:0] left_mem  [MAX_INTERNAL_NODES];
	logic [NODE_W-1:0] right_mem [MAX_INTERNAL_NODES];
	logic [ENT_W-1:0]  stk_mem   [MAX_INTERNAL_NODES];
	logic [NODE_W-1:0] lc_q, rc_q;
	logic [ENT_W-1:0]  stk_rd_q;

	// ------------------------------------------------------------------
	// Shared conditions
	// ------------------------------------------------------------------
	logic                   bit_v, b, out_free, node_full, tos_filled;
	logic                   walk_ended, walk_last, clear;
	logic [SLOT_W-1:0]      tos_slot, walk_slot_d, stk_rd_idx, stk_wr_idx;
	logic [DEPTH_W-1:0]     depth_m1, depth_m2;
	logic [NODE_W-1:0]      walk_child;
	logic [LENGTH_BITS-1:0] bytes_inc;

	assign bit_v       = fd_st.avail;
	assign b           = fd_st.cur_bit;
	assign out_free    = !out_valid_q || result.ready;
	assign node_full   = (node_cnt_q == DEPTH_W'(MAX_INTERNAL_NODES));
	assign tos_filled  = tos_q[ENT_W-1];
	assign tos_slot    = tos_q[SLOT_W-1:0];
	assign depth_m1    = depth_q - DEPTH_W'(1);
	assign depth_m2    = depth_q - DEPTH_W'(2);
	assign stk_wr_idx  = depth_m1[SLOT_W-1:0];
	assign stk_rd_idx  = depth_m2[SLOT_W-1:0];
	assign walk_child  = b ? rc_q : lc_q;
	assign walk_ended  = (bytes_q >= out_len_q);
	assign bytes_inc   = bytes_q + LENGTH_BITS'(1);
	assign walk_last   = (bytes_inc >= out_len_q);
	assign clear       = fd_st.load && fd_st.start;

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			htsd_pkg::ST_BUILD: begin
				if (bit_v) begin
					if (leaf_cnt_q != '0) begin
						if (leaf_cnt_q == htsd_pkg::BIT_CNT_W'(1)) begin
							state_d = htsd_pkg::ST_ATTACH;
						end
					end else if (b && node_full && out_free) begin
						state_d = htsd_pkg::ST_DONE;
					end
				end
			end
			htsd_pkg::ST_ATTACH: begin
				if (depth_q == '0) begin
					if (out_len_q == '0) begin
						state_d = htsd_pkg::ST_DONE;
					end else if (!v_q[NODE_W-1]) begin
						if (out_free) begin
							state_d = htsd_pkg::ST_DONE;
						end
					end else begin
						state_d = htsd_pkg::ST_WALK;
					end
				end else if (!tos_filled) begin
					state_d = htsd_pkg::ST_BUILD;
				end else if (depth_q > DEPTH_W'(1)) begin
					state_d = htsd_pkg::ST_LOAD;
				end
			end
			htsd_pkg::ST_LOAD: begin
				state_d = htsd_pkg::ST_ATTACH;
			end
			htsd_pkg::ST_WALK: begin
				if (bit_v) begin
					if (walk_ended) begin
						state_d = htsd_pkg::ST_DONE;
					end else if (!walk_child[NODE_W-1] && out_free && walk_last) begin
						state_d = htsd_pkg::ST_DONE;
					end
				end
			end
			htsd_pkg::ST_DONE: begin
				state_d = htsd_pkg::ST_DONE;
			end
			default: begin
				state_d = htsd_pkg::ST_BUILD;
			end
		endcase
	end

	// a new chunk overrides whatever the last bit of the old one decided
	assign state_n = clear ? htsd_pkg::ST_BUILD : state_d;

	// ------------------------------------------------------------------
	// Actions
	// ------------------------------------------------------------------
	logic              take, flush, push, leaf_start, leaf_shift, leaf_end;
	logic              wr_left, wr_right, tos_load, walk_emit;
	logic              emit;
	logic [BYTE_W-1:0] emit_sym;
	logic [REP_W-1:0]  emit_rep;
	logic              emit_last, emit_err;

	always_comb begin
		take       = 1'b0;
		flush      = 1'b0;
		push       = 1'b0;
		leaf_start = 1'b0;
		leaf_shift = 1'b0;
		leaf_end   = 1'b0;
		wr_left    = 1'b0;
		wr_right   = 1'b0;
		tos_load   = 1'b0;
		walk_emit  = 1'b0;
		emit       = 1'b0;
		emit_sym   = '0;
		emit_rep   = '0;
		emit_last  = 1'b0;
		emit_err   = 1'b0;
		walk_d     = walk_q;
		unique case (state_q)
			htsd_pkg::ST_BUILD: begin
				if (bit_v) begin
					if (leaf_cnt_q != '0) begin
						take       = 1'b1;
						leaf_shift = 1'b1;
						leaf_end   = (leaf_cnt_q == htsd_pkg::BIT_CNT_W'(1));
					end else if (!b) begin
						take       = 1'b1;
						leaf_start = 1'b1;
					end else if (!node_full) begin
						take = 1'b1;
						push = 1'b1;
					end else if (out_free) begin
						// too many internal nodes: report and stop
						take      = 1'b1;
						emit      = 1'b1;
						emit_last = 1'b1;
						emit_err  = 1'b1;
					end
				end
			end
			htsd_pkg::ST_ATTACH: begin
				if (depth_q == '0) begin
					walk_d = v_q;
					if (out_len_q != '0 && !v_q[NODE_W-1] && out_free) begin
						// single-leaf tree: one result covers the whole length
						emit      = 1'b1;
						emit_sym  = v_q[BYTE_W-1:0];
						emit_rep  = REP_W'(out_len_q);
						emit_last = 1'b1;
					end
				end else if (!tos_filled) begin
					wr_left = 1'b1;
				end else begin
					wr_right = 1'b1;
				end
			end
			htsd_pkg::ST_LOAD: begin
				tos_load = 1'b1;
			end
			htsd_pkg::ST_WALK: begin
				if (bit_v) begin
					if (walk_ended) begin
						take = 1'b1;
					end else if (walk_child[NODE_W-1]) begin
						take   = 1'b1;
						walk_d = walk_child;
					end else if (out_free) begin
						take      = 1'b1;
						walk_emit = 1'b1;
						walk_d    = root_q;
						emit      = 1'b1;
						emit_sym  = walk_child[BYTE_W-1:0];
						emit_rep  = REP_W'(1);
						emit_last = walk_last;
					end
				end
			end
			htsd_pkg::ST_DONE: begin
				flush = 1'b1;
			end
			default: begin
				flush = 1'b1;
			end
		endcase
	end

	assign fd_ctl.take  = take;
	assign fd_ctl.flush = flush;
	assign fd_ctl.hold  = (state_d == htsd_pkg::ST_ATTACH) || (state_d == htsd_pkg::ST_LOAD);

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= htsd_pkg::ST_BUILD;
			out_len_q   <= '0;
			depth_q     <= '0;
			node_cnt_q  <= '0;
			leaf_cnt_q  <= '0;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (cfg_we) begin
				out_len_q <= cfg_data;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (result.ready) begin
				out_valid_q <= 1'b0;
			end
			if (clear) begin
				depth_q    <= '0;
				node_cnt_q <= '0;
				leaf_cnt_q <= '0;
				bytes_q    <= '0;
			end else begin
				if (push) begin
					depth_q    <= depth_q + DEPTH_W'(1);
					node_cnt_q <= node_cnt_q + DEPTH_W'(1);
				end else if (wr_right) begin
					depth_q <= depth_m1;
				end
				if (leaf_start) begin
					leaf_cnt_q <= htsd_pkg::BIT_CNT_W'(BYTE_W);
				end else if (leaf_shift) begin
					leaf_cnt_q <= leaf_cnt_q - htsd_pkg::BIT_CNT_W'(1);
				end
				if (walk_emit) begin
					bytes_q <= bytes_inc;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		walk_q <= walk_d;
		if (emit) begin
			sym_q  <= emit_sym;
			rep_q  <= emit_rep;
			last_q <= emit_last;
			err_q  <= emit_err;
		end
		if (leaf_start) begin
			leaf_val_q <= '0;
		end else if (leaf_shift) begin
			leaf_val_q <= {leaf_val_q[BYTE_W-2:0], b};
		end
		if (leaf_end) begin
			v_q <= {1'b0, leaf_val_q[BYTE_W-2:0], b};
		end else if (wr_right) begin
			// the closed node becomes the subtree to attach one level up
			v_q <= {1'b1, (NODE_W-1)'(tos_slot)};
		end
		if (push) begin
			tos_q <= {1'b0, node_cnt_q[SLOT_W-1:0]};
		end else if (wr_left) begin
			tos_q <= {1'b1, tos_slot};
		end else if (tos_load) begin
			tos_q <= stk_rd_q;
		end
		if (state_q == htsd_pkg::ST_ATTACH && depth_q == '0) begin
			root_q <= v_q;
		end
	end

	// ------------------------------------------------------------------
	// RAMs
	// ------------------------------------------------------------------
	assign walk_slot_d = walk_d[SLOT_W-1:0];

	// child links: prefetch both children of the next walk node
	always_ff @(posedge clk) begin
		if (wr_left) begin
			left_mem[tos_slot] <= v_q;
		end
		if (wr_right) begin
			right_mem[tos_slot] <= v_q;
		end
		lc_q <= left_mem[walk_slot_d];
		rc_q <= right_mem[walk_slot_d];
	end

	// stack: spill the old top on push, fetch the entry below on pop
	always_ff @(posedge clk) begin
		if (push && depth_q != '0) begin
			stk_mem[stk_wr_idx] <= tos_q;
		end
		stk_rd_q <= stk_mem[stk_rd_idx];
	end

	// ------------------------------------------------------------------
	// Result port
	// ------------------------------------------------------------------
	assign result.valid        = out_valid_q;
	assign result.symbol       = sym_q;
	assign result.repeat_count = rep_q;
	assign result.last         = last_q;
	assign result.tree_error   = err_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_depth_le_nodes: assert property (@(posedge clk) disable iff (!arst_n)
		depth_q <= node_cnt_q)
		else $error("build stack deeper than the internal nodes allocated");

	a_walk_internal: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == htsd_pkg::ST_WALK |-> walk_q[NODE_W-1])
		else $error("walk sits on a leaf");

	a_no_load_in_attach: assert property (@(posedge clk) disable iff (!arst_n)
		(state_d == htsd_pkg::ST_ATTACH || state_d == htsd_pkg::ST_LOAD) |-> !fd_st.load)
		else $error("new byte loaded while a subtree is being attached");

	a_error_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		emit && emit_err |-> emit_last && state_n != htsd_pkg::ST_WALK)
		else $error("tree error result must end the chunk");

	a_emit_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q && $past(out_free))
		else $error("result overwritten while still waiting");

endmodule

// File: src/htsd_bit_feeder.sv
// One-byte input buffer and MSB-first shift register handing out one bit per cycle while the sequencer takes bits.
// Depends on htsd_pkg and htsd_in_if.
module htsd_bit_feeder (
	input  logic                 clk,
	input  logic                 arst_n,
	htsd_in_if.sink              stream,
	input  htsd_pkg::feed_ctl_t  ctl,
	output htsd_pkg::feed_stat_t st
);

	logic                             buf_valid_q;
	logic [htsd_pkg::BYTE_W-1:0]      buf_byte_q;
	logic                             buf_start_q;
	logic [htsd_pkg::BYTE_W-1:0]      sh_q;
	logic [htsd_pkg::BIT_CNT_W-1:0]   bits_q;
	logic [htsd_pkg::BIT_CNT_W-1:0]   bits_after;
	logic                             load;
	logic                             accept;

	always_comb begin
		priority if (ctl.flush) begin
			bits_after = '0;
		end else if (ctl.take) begin
			bits_after = bits_q - htsd_pkg::BIT_CNT_W'(1);
		end else begin
			bits_after = bits_q;
		end
	end

	assign load         = buf_valid_q && (bits_after == '0) && !ctl.hold;
	assign stream.ready = !buf_valid_q || load;
	assign accept       = stream.valid && stream.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_valid_q <= 1'b0;
			bits_q      <= '0;
		end else begin
			buf_valid_q <= accept || (buf_valid_q && !load);
			bits_q      <= load ? htsd_pkg::BIT_CNT_W'(htsd_pkg::BYTE_W) : bits_after;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			buf_byte_q  <= stream.data_byte;
			buf_start_q <= stream.chunk_start;
		end
		if (load) begin
			sh_q <= buf_byte_q;
		end else if (ctl.take) begin
			sh_q <= {sh_q[htsd_pkg::BYTE_W-2:0], 1'b0};
		end
	end

	assign st.avail   = (bits_q != '0);
	assign st.cur_bit = sh_q[htsd_pkg::BYTE_W-1];
	assign st.load    = load;
	assign st.start   = buf_start_q;

endmodule
